// ===== rtl/owtsr_pkg.sv =====
// Package for the 1-Wire temperature sensor read sequencer: codes, widths, CRC-8 helper.
package owtsr_pkg;

    localparam int CMD_W      = 2;
    localparam int ACT_W      = 2;
    localparam int STAT_W     = 3;
    localparam int WAIT_W     = 27;
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 4;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    // host commands
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd2;

    // bus master actions
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RESET = 2'd1;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd3;

    // 1-Wire command bytes
    localparam logic [7:0] OW_SKIP_ROM     = 8'hCC;
    localparam logic [7:0] OW_CONVERT      = 8'h44;
    localparam logic [7:0] OW_READ_SCRATCH = 8'hBE;

    localparam logic [15:0]       ERR_PATTERN   = 16'hFA5A;
    localparam logic [WAIT_W-1:0] WAIT_RESET    = 27'd1000000;
    localparam logic [TIME_W-1:0] WAIT_NEGATIVE = 32'h0800_0000;
    localparam logic [CNT_W-1:0]  SCRATCH_DONE  = 4'd10;  // nine reads issued plus one
    localparam logic [CNT_W-1:0]  CRC_BYTES     = 4'd8;
    localparam logic [7:0]        CRC_POLY      = 8'h8C;

    localparam logic [STAT_W-1:0] STAT_IDLE     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_READING  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_READY    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_CRCERR   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOSENSOR = 3'd4;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b000_0001,
        ST_PRESENCE1 = 7'b000_0010,
        ST_CONVERT   = 7'b000_0100,
        ST_WAIT      = 7'b000_1000,
        ST_PRESENCE2 = 7'b001_0000,
        ST_READCMD   = 7'b010_0000,
        ST_READING   = 7'b100_0000
    } seq_state_t;

    // Dallas CRC-8, LSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        logic       mix;
        crc = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            mix = crc[0] ^ data[i];
            crc = {1'b0, crc[7:1]};
            if (mix)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/onewire_temp_sensor_reader.sv =====
// 1-Wire temperature sensor read sequencer: presence, convert, wait, scratchpad read, CRC-8 check.
// An accepted input word is held in the input register; its result word is then registered in the result register.
// Throughput: one word per cycle while results are taken; input register -> step logic -> result register.
// The input register advances whenever the result register is empty or being taken.
// Reset (rst_n low, async): sequencer idle, status idle, temperature 0xFA5A,
// wait register 1000000 us, both pipeline registers empty.
module onewire_temp_sensor_reader
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [owtsr_pkg::WAIT_W-1:0]        cfg_wr_data,   // conversion_wait_us
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // bus_ready, present, read_byte, now_us, zero fill
    input  logic [owtsr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic [owtsr_pkg::CMD_W-1:0]         s_axis_tuser,  // command
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // bus_byte, temperature, sensor_status, start_accepted, zero fill
    output logic [owtsr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic [owtsr_pkg::ACT_W-1:0]         m_axis_tuser   // bus_action
);

    // configuration
    logic [owtsr_pkg::WAIT_W-1:0] wait_cfg_reg;

    // input stage
    logic                            in_valid_reg;
    logic [owtsr_pkg::CMD_W-1:0]     in_cmd_reg;
    logic                            in_bus_ready_reg;
    logic                            in_present_reg;
    logic [7:0]                      in_byte_reg;
    logic [owtsr_pkg::TIME_W-1:0]    in_now_reg;

    // sequencer state
    owtsr_pkg::seq_state_t           step_reg, step_next;
    logic [owtsr_pkg::CNT_W-1:0]     byte_count_reg, byte_count_next;
    logic [7:0]                      scratch_low_reg, scratch_low_next;
    logic [7:0]                      scratch_high_reg, scratch_high_next;
    logic [7:0]                      crc_reg, crc_next;
    logic [owtsr_pkg::TIME_W-1:0]    wait_left_reg, wait_left_next;
    logic [owtsr_pkg::TIME_W-1:0]    last_time_reg, last_time_next;
    logic [15:0]                     temp_reg, temp_next;
    logic [owtsr_pkg::STAT_W-1:0]    status_reg, status_next;

    // result stage
    logic                            out_valid_reg;
    logic [owtsr_pkg::ACT_W-1:0]     out_action_reg, action_next;
    logic [7:0]                      out_byte_reg, wbyte_next;
    logic [15:0]                     out_temp_reg;
    logic [owtsr_pkg::STAT_W-1:0]    out_status_reg;
    logic                            out_start_reg, start_next;

    logic                            advance;
    logic [owtsr_pkg::TIME_W-1:0]    wait_sub;
    logic [owtsr_pkg::CNT_W-1:0]     byte_idx;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_action_reg;
    assign m_axis_tdata  = {4'd0, out_start_reg, out_status_reg, out_temp_reg, out_byte_reg};

    assign wait_sub = wait_left_reg - (in_now_reg - last_time_reg);
    assign byte_idx = byte_count_reg - 4'd1;

    always_comb
    begin
        step_next         = step_reg;
        byte_count_next   = byte_count_reg;
        scratch_low_next  = scratch_low_reg;
        scratch_high_next = scratch_high_reg;
        crc_next          = crc_reg;
        wait_left_next    = wait_left_reg;
        last_time_next    = last_time_reg;
        temp_next         = temp_reg;
        status_next       = status_reg;
        action_next       = owtsr_pkg::ACT_NONE;
        wbyte_next        = 8'd0;
        start_next        = 1'b0;

        if (in_cmd_reg == owtsr_pkg::CMD_START)
        begin
            if (in_bus_ready_reg)
            begin
                action_next = owtsr_pkg::ACT_RESET;
                step_next   = owtsr_pkg::ST_PRESENCE1;
                status_next = owtsr_pkg::STAT_READING;
                start_next  = 1'b1;
            end
        end
        else if (in_cmd_reg == owtsr_pkg::CMD_TAKE)
        begin
            status_next = owtsr_pkg::STAT_IDLE;
        end
        else if (in_cmd_reg == owtsr_pkg::CMD_STEP && in_bus_ready_reg)
        begin
            case (step_reg)
                owtsr_pkg::ST_IDLE:
                begin
                end
                owtsr_pkg::ST_PRESENCE1:
                begin
                    if (in_present_reg)
                    begin
                        action_next = owtsr_pkg::ACT_WRITE;
                        wbyte_next  = owtsr_pkg::OW_SKIP_ROM;
                        step_next   = owtsr_pkg::ST_CONVERT;
                    end
                    else
                    begin
                        step_next   = owtsr_pkg::ST_IDLE;
                        temp_next   = owtsr_pkg::ERR_PATTERN;
                        status_next = owtsr_pkg::STAT_NOSENSOR;
                    end
                end
                owtsr_pkg::ST_CONVERT:
                begin
                    action_next    = owtsr_pkg::ACT_WRITE;
                    wbyte_next     = owtsr_pkg::OW_CONVERT;
                    step_next      = owtsr_pkg::ST_WAIT;
                    wait_left_next = {{(owtsr_pkg::TIME_W-owtsr_pkg::WAIT_W){1'b0}}, wait_cfg_reg};
                    last_time_next = in_now_reg;
                end
                owtsr_pkg::ST_WAIT:
                begin
                    wait_left_next = wait_sub;
                    last_time_next = in_now_reg;
                    // wait ends once the remaining time has gone negative
                    if (wait_sub > owtsr_pkg::WAIT_NEGATIVE)
                    begin
                        byte_count_next = '0;
                        step_next       = owtsr_pkg::ST_PRESENCE2;
                        action_next     = owtsr_pkg::ACT_RESET;
                    end
                end
                owtsr_pkg::ST_PRESENCE2:
                begin
                    if (in_present_reg)
                    begin
                        action_next = owtsr_pkg::ACT_WRITE;
                        wbyte_next  = owtsr_pkg::OW_SKIP_ROM;
                        step_next   = owtsr_pkg::ST_READCMD;
                    end
                    else
                    begin
                        step_next   = owtsr_pkg::ST_IDLE;
                        status_next = owtsr_pkg::STAT_NOSENSOR;
                    end
                end
                owtsr_pkg::ST_READCMD:
                begin
                    action_next     = owtsr_pkg::ACT_WRITE;
                    wbyte_next      = owtsr_pkg::OW_READ_SCRATCH;
                    byte_count_next = '0;
                    crc_next        = 8'd0;
                    step_next       = owtsr_pkg::ST_READING;
                end
                owtsr_pkg::ST_READING:
                begin
                    // byte_count counts reads issued; the byte in hand belongs to the previous read
                    if (byte_count_reg != '0)
                    begin
                        if (byte_idx == 4'd0)
                        begin
                            scratch_low_next = in_byte_reg;
                        end
                        if (byte_idx == 4'd1)
                        begin
                            scratch_high_next = in_byte_reg;
                        end
                        if (byte_idx < owtsr_pkg::CRC_BYTES)
                        begin
                            crc_next = owtsr_pkg::crc8_byte(crc_reg, in_byte_reg);
                        end
                    end
                    if (byte_count_reg + 4'd1 == owtsr_pkg::SCRATCH_DONE)
                    begin
                        step_next       = owtsr_pkg::ST_IDLE;
                        byte_count_next = '0;
                        if (in_byte_reg == crc_next)
                        begin
                            temp_next   = {scratch_high_next, scratch_low_next};
                            status_next = owtsr_pkg::STAT_READY;
                        end
                        else
                        begin
                            temp_next   = owtsr_pkg::ERR_PATTERN;
                            status_next = owtsr_pkg::STAT_CRCERR;
                        end
                    end
                    else
                    begin
                        byte_count_next = byte_count_reg + 4'd1;
                        action_next     = owtsr_pkg::ACT_READ;
                    end
                end
                default:
                begin
                    step_next = owtsr_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_cfg_reg <= owtsr_pkg::WAIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            wait_cfg_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_cmd_reg       <= s_axis_tuser;
            in_bus_ready_reg <= s_axis_tdata[0];
            in_present_reg   <= s_axis_tdata[1];
            in_byte_reg      <= s_axis_tdata[9:2];
            in_now_reg       <= s_axis_tdata[41:10];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= owtsr_pkg::ST_IDLE;
            byte_count_reg <= '0;
            crc_reg        <= 8'd0;
            wait_left_reg  <= '0;
            last_time_reg  <= '0;
            temp_reg       <= owtsr_pkg::ERR_PATTERN;
            status_reg     <= owtsr_pkg::STAT_IDLE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                step_reg       <= step_next;
                byte_count_reg <= byte_count_next;
                crc_reg        <= crc_next;
                wait_left_reg  <= wait_left_next;
                last_time_reg  <= last_time_next;
                temp_reg       <= temp_next;
                status_reg     <= status_next;
                out_valid_reg  <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            scratch_low_reg  <= scratch_low_next;
            scratch_high_reg <= scratch_high_next;
            out_action_reg   <= action_next;
            out_byte_reg     <= wbyte_next;
            out_temp_reg     <= temp_next;
            out_status_reg   <= status_next;
            out_start_reg    <= start_next;
        end
    end

    // an accepted start always asks for a bus reset
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_start_reg) |-> (out_action_reg == owtsr_pkg::ACT_RESET))
        else $error("start accepted without bus reset");

    // a command byte is only driven with a write action
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_byte_reg != 8'd0) |-> (out_action_reg == owtsr_pkg::ACT_WRITE))
        else $error("bus byte set without write action");

    // read counter never runs past the scratchpad length
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg < owtsr_pkg::SCRATCH_DONE)
        else $error("byte counter out of range");

    // every item taken from the input register shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after advance");

    // ready status only ever follows a read sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && status_next == owtsr_pkg::STAT_READY && status_reg != owtsr_pkg::STAT_READY)
            |-> (step_reg == owtsr_pkg::ST_READING))
        else $error("ready status outside read sequence");

endmodule
